// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module of the register port.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PPU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("register port assertion failed");

// Clocked assertion that is also checked while reset is asserted.
`define PPU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("register port assertion failed during reset");

`endif

// ===== rtl/core/ppu_pkg.sv =====
// Shared constants, types and helper function of the picture-unit register port.
package ppu_pkg;

  localparam int PATTERN_DEPTH = 8192;
  localparam int PALETTE_DEPTH = 32;
  localparam int PAT_AW = $clog2(PATTERN_DEPTH);
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_ADDRESS = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  localparam logic [15:0] INC_NARROW = 16'd1;
  localparam logic [15:0] INC_WIDE   = 16'd32;

  localparam logic [5:0] PALETTE_PAGE = 6'h3F;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_STATUS,
    ACC_DATA
  } ppu_acc_e;

  // Bookkeeping for a transaction whose store read is in flight.
  typedef struct packed {
    ppu_acc_e   acc;
    logic       pat_hit;
    logic       pal_hit;
    logic       pal_valid;
    logic [2:0] status_hi;
  } ppu_stage_t;

  // Entries 0x10, 0x14, 0x18 and 0x1C mirror the backdrop entries below them.
  function automatic logic [PAL_AW-1:0] palette_slot(input logic [13:0] addr);
    logic [4:0] slot;
    slot = addr[4:0];
    if (slot[4] && (slot[1:0] == 2'b00)) begin
      slot[4] = 1'b0;
    end
    return slot[PAL_AW-1:0];
  endfunction

endpackage

// ===== rtl/core/ppu_register_port.sv =====
// A transaction waits in the stage register for its registered pattern or palette RAM read;
// its result then moves to the output register. Throughput: one transaction per cycle while
// results are taken; the output register lets a new transaction in while a result waits.
// Reset clears control, status, pointer, address latch, read buffer and palette valid
// flags at once; unwritten palette entries read as zero, pattern entries are undefined
// until written. No clearing pass runs after reset.
module ppu_register_port import ppu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] write_data
  input  logic [3:0] s_axis_tuser_i,   // [0] req_type, [3:1] reg_index
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [7:0] read_data
);

  logic                     req_write;
  logic [2:0]               reg_idx;
  logic [7:0]               wr_byte;
  logic                     accept;
  logic                     data_wr;
  logic                     data_rd;

  logic [7:0]               control_q, control_d;
  logic [7:0]               status_q, status_d;
  logic                     phase_q, phase_d;
  logic [15:0]              ptr_q, ptr_d;
  logic [7:0]               rbuf_q, rbuf_d;
  logic [PALETTE_DEPTH-1:0] pal_valid_q, pal_valid_d;

  logic                     s1_valid_q, s1_valid_d;
  ppu_stage_t               stage_q, stage_d;
  logic                     s1_advance;

  logic                     out_valid_q, out_valid_d;
  logic [7:0]               out_data_q, out_data_d;

  logic [13:0]              store_addr;
  logic                     pat_hit;
  logic                     pal_hit;
  logic [PAL_AW-1:0]        pal_slot;
  logic [15:0]              ptr_inc;

  logic                     pat_en;
  logic                     pal_en;
  logic [7:0]               pat_rdata;
  logic [7:0]               pal_rdata;
  logic [7:0]               load_byte;
  logic [7:0]               result;

  assign req_write = s_axis_tuser_i[0];
  assign reg_idx   = s_axis_tuser_i[3:1];
  assign wr_byte   = s_axis_tdata_i;

  assign s1_advance      = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign data_wr = accept && (reg_idx == REG_DATA) && (req_write == REQ_WRITE);
  assign data_rd = accept && (reg_idx == REG_DATA) && (req_write == REQ_READ);

  assign store_addr = ptr_q[13:0];
  assign pat_hit    = !store_addr[13];
  assign pal_hit    = (store_addr[13:8] == PALETTE_PAGE);
  assign pal_slot   = palette_slot(store_addr);
  assign ptr_inc    = control_q[2] ? INC_WIDE : INC_NARROW;

  assign pat_en = (data_wr || data_rd) && pat_hit;
  assign pal_en = (data_wr || data_rd) && pal_hit;

  ppu_ram #(
    .Width (8),
    .Depth (PATTERN_DEPTH)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .en_i    (pat_en),
    .we_i    (data_wr),
    .addr_i  (ptr_q[PAT_AW-1:0]),
    .wdata_i (wr_byte),
    .rdata_o (pat_rdata)
  );

  ppu_ram #(
    .Width (8),
    .Depth (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .en_i    (pal_en),
    .we_i    (data_wr),
    .addr_i  (pal_slot),
    .wdata_i (wr_byte),
    .rdata_o (pal_rdata)
  );

  // Accept stage: register file updates, pointer handling and store access issue.
  // Mask writes are accepted but have no visible effect in this block.
  always_comb begin
    control_d   = control_q;
    status_d    = status_q;
    phase_d     = phase_q;
    ptr_d       = ptr_q;
    pal_valid_d = pal_valid_q;

    stage_d           = stage_q;
    stage_d.acc       = ACC_NONE;
    stage_d.pat_hit   = pat_hit;
    stage_d.pal_hit   = pal_hit;
    stage_d.pal_valid = pal_valid_q[pal_slot];
    stage_d.status_hi = status_q[7:5];

    if (accept) begin
      if (req_write == REQ_WRITE) begin
        unique case (reg_idx)
          REG_CONTROL: control_d = wr_byte;
          REG_STATUS:  status_d  = wr_byte;
          REG_ADDRESS: begin
            if (!phase_q) begin
              ptr_d   = {wr_byte, ptr_q[7:0]};
              phase_d = 1'b1;
            end else begin
              ptr_d   = {ptr_q[15:8], wr_byte};
              phase_d = 1'b0;
            end
          end
          REG_DATA: begin
            ptr_d = ptr_q + ptr_inc;
            if (pal_hit) begin
              pal_valid_d[pal_slot] = 1'b1;
            end
          end
          default: ;
        endcase
      end else begin
        unique case (reg_idx)
          REG_STATUS: begin
            stage_d.acc = ACC_STATUS;
            status_d[7] = 1'b0;
            phase_d     = 1'b0;
          end
          REG_DATA: begin
            stage_d.acc = ACC_DATA;
            ptr_d       = ptr_q + ptr_inc;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // Result stage: the store data has arrived and the read buffer is updated in order.
  always_comb begin
    if (stage_q.pat_hit) begin
      load_byte = pat_rdata;
    end else if (stage_q.pal_hit && stage_q.pal_valid) begin
      load_byte = pal_rdata;
    end else begin
      load_byte = 8'h00;
    end

    rbuf_d = rbuf_q;
    case (stage_q.acc)
      ACC_STATUS: result = {stage_q.status_hi, rbuf_q[4:0]};
      ACC_DATA: begin
        // Palette reads bypass the buffer and return the fresh byte.
        result = stage_q.pal_hit ? load_byte : rbuf_q;
        if (s1_advance) begin
          rbuf_d = load_byte;
        end
      end
      default: result = 8'h00;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (s1_advance) begin
      out_valid_d = 1'b1;
      out_data_d  = result;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q   <= '0;
      status_q    <= '0;
      phase_q     <= 1'b0;
      ptr_q       <= '0;
      rbuf_q      <= '0;
      pal_valid_q <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      control_q   <= control_d;
      status_q    <= status_d;
      phase_q     <= phase_d;
      ptr_q       <= ptr_d;
      rbuf_q      <= rbuf_d;
      pal_valid_q <= pal_valid_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== rtl/core/ppu_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module ppu_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ppu_checker.sv =====
// Port-level checks of the register port, attached to the top level by bind.
`include "assert_macros.svh"

module ppu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic [3:0] s_axis_tuser_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  logic in_xact;
  logic out_stall;
  logic payload_seen;

  assign in_xact   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  // Keeps the input payload ports in the checker's view.
  assign payload_seen = ^{s_axis_tdata_i, s_axis_tuser_i} || 1'b1;

  // A result that is not taken holds its value.
  `PPU_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))

  // With the consumer ready the block always takes a new transaction.
  `PPU_ASSERT(a_ready_follows, clk_i, rst_ni, (m_axis_tready_i && payload_seen) |-> s_axis_tready_o)

  // A result only rises on an empty output for a transaction that has passed the stage register.
  `PPU_ASSERT(a_latency, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(in_xact, 2))

  // No result is pending right after reset.
  `PPU_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind ppu_register_port ppu_checker u_ppu_checker (.*);

// ===== test/ppu_register_port_tb.sv =====
// Testbench for the register port: directed and random CPU register accesses checked against a shadow model.
`timescale 1ns / 100ps

module ppu_register_port_tb;
  import ppu_pkg::*;

  // Registers 3, 4 and 5 are decoded but do nothing.
  localparam logic [2:0] REG_SPARE_LO = 3'd3;
  localparam logic [2:0] REG_SPARE_HI = 3'd5;

  // Two copies of the shadow state: one follows the stimulus plan, one the bus.
  localparam int SHADOW_PLAN = 0;
  localparam int SHADOW_BUS  = 1;

  localparam int RANDOM_ITEMS = 550;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic       is_wr;
    logic [2:0] rg;
    logic [7:0] wd;
  } bus_access_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;   // [7:0] write_data
  logic [3:0] s_axis_tuser_i = 4'h0;    // [0] req_type, [3:1] reg_index
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [7:0] read_data

  logic [7:0]  ctrl_q [2];
  logic [7:0]  mask_q [2];
  logic [7:0]  stat_q [2];
  logic [7:0]  rbuf_q [2];
  logic        phase_q [2];
  logic [15:0] ptr_q [2];
  logic [7:0]  pal_mem [2][PALETTE_DEPTH];
  logic [7:0]  pat_mem [2][PATTERN_DEPTH];
  bit          pat_seen [2][PATTERN_DEPTH];

  bus_access_t pending_q[$];
  logic [7:0]  read_data_q[$];
  int          planned_cnt = 0;
  int          total_items = 0;
  int          accepted_cnt = 0;
  int          err_cnt = 0;
  int          idle_cycles = 0;
  logic [7:0]  want_data;
  logic [7:0]  got_data;

  ppu_register_port u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Applies one CPU access to shadow copy m and returns the byte it reads back.
  task automatic cpu_access(input int m, input bus_access_t acc, output logic [7:0] rd);
    logic [13:0] addr;
    logic [4:0]  slot;
    logic [7:0]  fetched;
    rd = 8'h00;
    addr = ptr_q[m][13:0];
    slot = (addr[4] && addr[1:0] == 2'b00) ? {1'b0, addr[3:0]} : addr[4:0];
    fetched = 8'h00;
    if (acc.is_wr == REQ_WRITE) begin
      case (acc.rg)
        REG_CONTROL: ctrl_q[m] = acc.wd;
        REG_MASK:    mask_q[m] = acc.wd;
        REG_STATUS:  stat_q[m] = acc.wd;
        REG_ADDRESS: begin
          if (!phase_q[m]) ptr_q[m][15:8] = acc.wd;
          else ptr_q[m][7:0] = acc.wd;
          phase_q[m] = !phase_q[m];
        end
        REG_DATA: begin
          if (addr < 14'h2000) begin
            pat_mem[m][addr % PATTERN_DEPTH] = acc.wd;
            pat_seen[m][addr % PATTERN_DEPTH] = 1'b1;
          end else if (addr[13:8] == PALETTE_PAGE) begin
            pal_mem[m][slot] = acc.wd;
          end
          ptr_q[m] = ptr_q[m] + (ctrl_q[m][2] ? INC_WIDE : INC_NARROW);
        end
        default: ;
      endcase
    end else if (acc.rg == REG_STATUS) begin
      rd = {stat_q[m][7:5], rbuf_q[m][4:0]};
      stat_q[m][7] = 1'b0;
      phase_q[m] = 1'b0;
    end else if (acc.rg == REG_DATA) begin
      rd = rbuf_q[m];
      if (addr < 14'h2000) fetched = pat_mem[m][addr % PATTERN_DEPTH];
      else if (addr[13:8] == PALETTE_PAGE) fetched = pal_mem[m][slot];
      rbuf_q[m] = fetched;
      // Palette reads bypass the buffer.
      if (addr[13:8] == PALETTE_PAGE) rd = fetched;
      ptr_q[m] = ptr_q[m] + (ctrl_q[m][2] ? INC_WIDE : INC_NARROW);
    end
  endtask

  // A data read that would fetch a never-written pattern byte becomes a data write.
  task automatic queue_access(input logic is_wr, input logic [2:0] rg, input logic [7:0] wd);
    bus_access_t acc;
    logic [7:0]  unused_rd;
    logic [13:0] addr;
    addr = ptr_q[SHADOW_PLAN][13:0];
    acc = '{is_wr: is_wr, rg: rg, wd: wd};
    if (is_wr == REQ_READ && rg == REG_DATA && addr < 14'h2000 &&
        !pat_seen[SHADOW_PLAN][addr % PATTERN_DEPTH]) begin
      acc.is_wr = REQ_WRITE;
      acc.wd = 8'($urandom);
    end
    cpu_access(SHADOW_PLAN, acc, unused_rd);
    pending_q.push_back(acc);
    planned_cnt++;
  endtask

  task automatic set_pointer(input logic [7:0] hi, input logic [7:0] lo);
    if (phase_q[SHADOW_PLAN]) queue_access(REQ_READ, REG_STATUS, 8'($urandom));
    queue_access(REQ_WRITE, REG_ADDRESS, hi);
    queue_access(REQ_WRITE, REG_ADDRESS, lo);
  endtask

  function automatic logic [7:0] random_page();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 8'($urandom_range(8'h00, 8'h1F));
    else if (pick < 80) return 8'(PALETTE_PAGE);
    else if (pick < 90) return 8'($urandom_range(8'h20, 8'h3E));
    else return 8'($urandom);
  endfunction

  task automatic report_mismatch(input string what);
    if (err_cnt < MAX_PRINTS) $display("mismatch: %s", what);
    err_cnt++;
  endtask

  // Pacing: 0 = sender gaps 15%, receiver stalls 74%; 1 = swapped; 2 = no idling.
  function automatic int pace_phase(input int cnt);
    if (cnt < total_items / 3) return 0;
    else if (cnt < (2 * total_items) / 3) return 1;
    else return 2;
  endfunction

  // Driver: presents the next pending access and runs the bus-side shadow on each transaction.
  always @(posedge clk_i) begin
    bus_access_t acc;
    logic [7:0]  rd;
    int          gap_pct;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        acc = '{is_wr: s_axis_tuser_i[0], rg: s_axis_tuser_i[3:1], wd: s_axis_tdata_i};
        cpu_access(SHADOW_BUS, acc, rd);
        read_data_q.push_back(rd);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        case (pace_phase(accepted_cnt))
          0: gap_pct = 15;
          1: gap_pct = 74;
          default: gap_pct = 0;
        endcase
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          acc = pending_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= {acc.rg, acc.is_wr};
          s_axis_tdata_i <= acc.wd;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest predicted byte.
  always @(posedge clk_i) begin
    int stall_pct;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_data = m_axis_tdata_o;
        if (read_data_q.size() == 0) begin
          report_mismatch($sformatf("read_data %02h with no result expected", got_data));
        end else begin
          want_data = read_data_q.pop_front();
          if (got_data !== want_data)
            report_mismatch($sformatf("read_data %02h, expected %02h", got_data, want_data));
        end
      end
      case (pace_phase(accepted_cnt))
        0: stall_pct = 74;
        1: stall_pct = 15;
        default: stall_pct = 0;
      endcase
      m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int burst;
    logic [7:0] hi;
    logic [7:0] lo;
    for (int m = 0; m < 2; m++) begin
      ctrl_q[m] = 8'h00;
      mask_q[m] = 8'h00;
      stat_q[m] = 8'h00;
      rbuf_q[m] = 8'h00;
      phase_q[m] = 1'b0;
      ptr_q[m] = 16'h0000;
      for (int i = 0; i < PALETTE_DEPTH; i++) pal_mem[m][i] = 8'h00;
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
        pat_mem[m][i] = 8'h00;
        pat_seen[m][i] = 1'b0;
      end
    end

    // Status after reset, full status write, and vblank clearing on read.
    queue_access(REQ_READ, REG_STATUS, 8'hFF);
    queue_access(REQ_WRITE, REG_STATUS, 8'hFF);
    queue_access(REQ_READ, REG_STATUS, 8'h00);
    queue_access(REQ_READ, REG_STATUS, 8'h00);
    queue_access(REQ_WRITE, REG_CONTROL, 8'hFF);
    queue_access(REQ_WRITE, REG_MASK, 8'hFF);
    queue_access(REQ_READ, REG_CONTROL, 8'h00);
    queue_access(REQ_READ, REG_MASK, 8'h00);
    queue_access(REQ_READ, REG_ADDRESS, 8'hFF);
    for (logic [2:0] r = REG_SPARE_LO; r <= REG_SPARE_HI; r++) begin
      queue_access(REQ_WRITE, r, 8'hFF);
      queue_access(REQ_READ, r, 8'h00);
    end
    queue_access(REQ_WRITE, REG_CONTROL, 8'h00);
    // Mirrored palette entry, then an immediate palette read through its alias.
    set_pointer(8'(PALETTE_PAGE), 8'h10);
    queue_access(REQ_WRITE, REG_DATA, 8'hFF);
    set_pointer(8'(PALETTE_PAGE), 8'h00);
    queue_access(REQ_READ, REG_DATA, 8'h00);
    // Buffered pattern read: the first read returns the stale buffer.
    set_pointer(8'h00, 8'h00);
    queue_access(REQ_WRITE, REG_DATA, 8'h00);
    queue_access(REQ_WRITE, REG_DATA, 8'hFF);
    set_pointer(8'h00, 8'h00);
    queue_access(REQ_READ, REG_DATA, 8'h00);
    queue_access(REQ_READ, REG_DATA, 8'h00);
    queue_access(REQ_READ, REG_STATUS, 8'h00);
    // A status read between the two address writes restarts the latch.
    queue_access(REQ_WRITE, REG_ADDRESS, 8'h12);
    queue_access(REQ_READ, REG_STATUS, 8'h00);
    // Nametable range, wide increment and pointer wrap past 0xFFFF.
    set_pointer(8'h20, 8'h00);
    queue_access(REQ_WRITE, REG_DATA, 8'h5A);
    queue_access(REQ_READ, REG_DATA, 8'h00);
    queue_access(REQ_WRITE, REG_CONTROL, 8'h04);
    set_pointer(8'hFF, 8'hF0);
    queue_access(REQ_WRITE, REG_DATA, 8'hA5);
    queue_access(REQ_READ, REG_DATA, 8'h00);

    while (planned_cnt < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      hi = random_page();
      lo = 8'($urandom);
      burst = $urandom_range(1, 6);
      if (pick < 35) begin
        // Fill a run, then rewind and read it back through the buffer.
        set_pointer(hi, lo);
        for (int i = 0; i < burst; i++) queue_access(REQ_WRITE, REG_DATA, 8'($urandom));
        set_pointer(hi, lo);
        for (int i = 0; i <= burst; i++) queue_access(REQ_READ, REG_DATA, 8'($urandom));
      end else if (pick < 50) begin
        set_pointer(hi, lo);
        for (int i = 0; i < burst; i++)
          queue_access(1'($urandom), REG_DATA, 8'($urandom));
      end else if (pick < 60) begin
        queue_access(REQ_WRITE, REG_CONTROL, 8'($urandom));
      end else if (pick < 72) begin
        queue_access(1'($urandom), REG_STATUS, 8'($urandom));
      end else if (pick < 78) begin
        queue_access(1'($urandom), $urandom_range(0, 1) ? REG_MASK : REG_CONTROL,
                     8'($urandom));
      end else if (pick < 85) begin
        queue_access(REQ_WRITE, REG_ADDRESS, 8'($urandom));
      end else begin
        queue_access(1'($urandom), 3'($urandom), 8'($urandom));
      end
    end
    total_items = pending_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || s_axis_tvalid_i || read_data_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ppu_pkg.sv
rtl/core/ppu_ram.sv
rtl/core/ppu_register_port.sv
rtl/core/ppu_checker.sv
test/ppu_register_port_tb.sv
